### src/wind_vane_vector_averager_unit_macros.svh
// Assertion helpers for the wind vane averager checker.
// Both expect clk and arst_n to be visible where they are used.
`ifndef WIND_VANE_VECTOR_AVERAGER_UNIT_MACROS_SVH
`define WIND_VANE_VECTOR_AVERAGER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define WVVA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while in reset.
`define WVVA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/wvva_pkg.sv
// ----------------------------------------------------------------------------
// wvva_pkg
// Shared constants, tables and types of the wind vane vector averager.
// ----------------------------------------------------------------------------
`default_nettype none

package wvva_pkg;

	localparam int COUNT_BITS_DEF   = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int ADC_W      = 12;
	localparam int DEG_OUT_W  = 9;
	localparam int TRIG_W     = 16;   // Q1.15 cos/sin
	localparam int IDX_W      = 4;    // direction index and window index
	localparam int ATAN_IDX_W = 5;    // up to 32 angle table entries
	localparam int Z_W        = 27;   // angle accumulator, degrees Q.16
	localparam int FRAC_W     = 16;

	localparam logic [ADC_W-1:0] OPEN_LIMIT = 12'd4000;

	localparam logic signed [Z_W-1:0] DEG90_Q16  = 27'sd5898240;
	localparam logic signed [Z_W-1:0] DEG180_Q16 = 27'sd11796480;
	localparam logic signed [Z_W-1:0] ROUND_Q16  = 27'sd65535;

	typedef struct packed {
		logic                     hit;
		logic                     open_circuit;
		logic signed [TRIG_W-1:0] cos_v;
		logic signed [TRIG_W-1:0] sin_v;
	} wvva_win_t;

	typedef struct packed {
		logic busy;
		logic res_valid;
	} wvva_cordic_sts_t;

	// Window bounds [lo, hi) and direction index, in match priority order.
	function automatic logic [ADC_W-1:0] win_lo(input logic [IDX_W-1:0] w);
		logic [ADC_W-1:0] v;
		case (w)
			4'd0:    v = 12'd2200;
			4'd1:    v = 12'd2100;
			4'd2:    v = 12'd3200;
			4'd3:    v = 12'd3100;
			4'd4:    v = 12'd3890;
			4'd5:    v = 12'd3700;
			4'd6:    v = 12'd3780;
			4'd7:    v = 12'd3400;
			4'd8:    v = 12'd3570;
			4'd9:    v = 12'd2600;
			4'd10:   v = 12'd2750;
			4'd11:   v = 12'd1510;
			4'd12:   v = 12'd1580;
			4'd13:   v = 12'd1470;
			4'd14:   v = 12'd1900;
			default: v = 12'd1700;
		endcase
		return v;
	endfunction

	function automatic logic [ADC_W-1:0] win_hi(input logic [IDX_W-1:0] w);
		logic [ADC_W-1:0] v;
		case (w)
			4'd0:    v = 12'd2400;
			4'd1:    v = 12'd2200;
			4'd2:    v = 12'd3299;
			4'd3:    v = 12'd3200;
			4'd4:    v = 12'd3999;
			4'd5:    v = 12'd3780;
			4'd6:    v = 12'd3890;
			4'd7:    v = 12'd3500;
			4'd8:    v = 12'd3700;
			4'd9:    v = 12'd2700;
			4'd10:   v = 12'd2850;
			4'd11:   v = 12'd1580;
			4'd12:   v = 12'd1650;
			4'd13:   v = 12'd1510;
			4'd14:   v = 12'd2000;
			default: v = 12'd1750;
		endcase
		return v;
	endfunction

	function automatic logic [IDX_W-1:0] win_k(input logic [IDX_W-1:0] w);
		logic [IDX_W-1:0] v;
		case (w)
			4'd0:    v = 4'd8;
			4'd1:    v = 4'd9;
			4'd2:    v = 4'd10;
			4'd3:    v = 4'd11;
			4'd4:    v = 4'd12;
			4'd5:    v = 4'd13;
			4'd6:    v = 4'd14;
			4'd7:    v = 4'd15;
			4'd8:    v = 4'd0;
			4'd9:    v = 4'd1;
			4'd10:   v = 4'd2;
			4'd11:   v = 4'd3;
			4'd12:   v = 4'd4;
			4'd13:   v = 4'd5;
			4'd14:   v = 4'd6;
			default: v = 4'd7;
		endcase
		return v;
	endfunction

	// cos(k * 22.5 deg) in Q1.15
	function automatic logic signed [TRIG_W-1:0] cos_q15(input logic [IDX_W-1:0] k);
		logic signed [TRIG_W-1:0] v;
		case (k)
			4'd0:    v = 16'sd32767;
			4'd1:    v = 16'sd30274;
			4'd2:    v = 16'sd23170;
			4'd3:    v = 16'sd12540;
			4'd4:    v = 16'sd0;
			4'd5:    v = -16'sd12540;
			4'd6:    v = -16'sd23170;
			4'd7:    v = -16'sd30274;
			4'd8:    v = -16'sd32767;
			4'd9:    v = -16'sd30274;
			4'd10:   v = -16'sd23170;
			4'd11:   v = -16'sd12540;
			4'd12:   v = 16'sd0;
			4'd13:   v = 16'sd12540;
			4'd14:   v = 16'sd23170;
			default: v = 16'sd30274;
		endcase
		return v;
	endfunction

	// atan(2^-i) in degrees, Q.16
	function automatic logic signed [Z_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] i);
		logic signed [Z_W-1:0] v;
		case (i)
			5'd0:    v = 27'sd2949120;
			5'd1:    v = 27'sd1740967;
			5'd2:    v = 27'sd919879;
			5'd3:    v = 27'sd466945;
			5'd4:    v = 27'sd234379;
			5'd5:    v = 27'sd117304;
			5'd6:    v = 27'sd58666;
			5'd7:    v = 27'sd29335;
			5'd8:    v = 27'sd14668;
			5'd9:    v = 27'sd7334;
			5'd10:   v = 27'sd3667;
			5'd11:   v = 27'sd1833;
			5'd12:   v = 27'sd917;
			5'd13:   v = 27'sd458;
			5'd14:   v = 27'sd229;
			5'd15:   v = 27'sd115;
			5'd16:   v = 27'sd57;
			5'd17:   v = 27'sd29;
			5'd18:   v = 27'sd14;
			5'd19:   v = 27'sd7;
			5'd20:   v = 27'sd4;
			5'd21:   v = 27'sd2;
			5'd22:   v = 27'sd1;
			default: v = 27'sd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

### src/wvva_in_if.sv
// ----------------------------------------------------------------------------
// wvva_in_if
// Command channel: sample or read request, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface wvva_in_if;
	logic                         valid;
	logic                         ready;
	logic                         op;
	logic [wvva_pkg::ADC_W-1:0]   adc_sample;

	modport source (output valid, output op, output adc_sample, input ready);
	modport sink   (input valid, input op, input adc_sample, output ready);
endinterface

`default_nettype wire

### src/wvva_out_if.sv
// ----------------------------------------------------------------------------
// wvva_out_if
// Result channel: one result per command, valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface wvva_out_if;
	logic                             valid;
	logic                             ready;
	logic                             accepted;
	logic                             open_circuit;
	logic [wvva_pkg::DEG_OUT_W-1:0]   direction_deg;
	logic                             has_samples;

	modport source (output valid, output accepted, output open_circuit,
		output direction_deg, output has_samples, input ready);
	modport sink   (input valid, input accepted, input open_circuit,
		input direction_deg, input has_samples, output ready);
endinterface

`default_nettype wire

### src/wvva_window.sv
// ----------------------------------------------------------------------------
// wvva_window
// Maps a vane ADC reading to its direction window and unit vector.
// ----------------------------------------------------------------------------
`default_nettype none

module wvva_window (
	input  wire logic [wvva_pkg::ADC_W-1:0] adc_sample,
	output wvva_pkg::wvva_win_t             win
);

	logic                          hit;
	logic [wvva_pkg::IDX_W-1:0]    k;

	// Walk from the last window down so the first match in table order wins.
	always_comb begin
		hit = 1'b0;
		k   = '0;
		for (int w = 15; w >= 0; w--) begin
			if (adc_sample >= wvva_pkg::win_lo(4'(w)) && adc_sample < wvva_pkg::win_hi(4'(w))) begin
				hit = 1'b1;
				k   = wvva_pkg::win_k(4'(w));
			end
		end
	end

	always_comb begin
		win.hit          = hit;
		win.open_circuit = adc_sample > wvva_pkg::OPEN_LIMIT;
		win.cos_v        = wvva_pkg::cos_q15(k);
		// sin(a) = cos(a - 90 deg): index offset by 12 of 16
		win.sin_v        = wvva_pkg::cos_q15(4'(k + 4'd12));
	end

endmodule

`default_nettype wire

### src/wvva_cordic.sv
// ----------------------------------------------------------------------------
// wvva_cordic
// Iterative vectoring CORDIC: angle of (x, y) in whole degrees, 0..359.
// One shift/add step per cycle; result held until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module wvva_cordic #(
	parameter int SUM_W        = wvva_pkg::COUNT_BITS_DEF + wvva_pkg::TRIG_W,
	parameter int CORDIC_STEPS = wvva_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	input  wire logic signed [SUM_W-1:0]           x_in,
	input  wire logic signed [SUM_W-1:0]           y_in,
	input  wire logic                              take,
	output wvva_pkg::wvva_cordic_sts_t             sts,
	output logic [wvva_pkg::DEG_OUT_W-1:0]         deg
);

	// two guard bits: pre-rotation negate plus CORDIC gain
	localparam int XY_W   = SUM_W + 2;
	localparam int ITER_W = $clog2(CORDIC_STEPS);
	localparam int DEG_W  = wvva_pkg::Z_W - wvva_pkg::FRAC_W;

	typedef enum logic [3:0] {
		C_IDLE = 4'b0001,
		C_RUN  = 4'b0010,
		C_FIN  = 4'b0100,
		C_HOLD = 4'b1000
	} cordic_state_t;

	cordic_state_t                     state_q;
	logic signed [XY_W-1:0]            x_q, y_q;
	logic signed [wvva_pkg::Z_W-1:0]   z_q;
	logic [ITER_W-1:0]                 iter_q;
	logic [wvva_pkg::DEG_OUT_W-1:0]    deg_q;

	logic signed [XY_W-1:0]            x_ext, y_ext, xs, ys;
	logic                              y_pos, y_neg, last_step;
	logic signed [wvva_pkg::Z_W-1:0]   atan_v, z_rnd;
	logic signed [DEG_W-1:0]           deg_w, deg_fix;

	assign x_ext     = XY_W'(x_in);
	assign y_ext     = XY_W'(y_in);
	assign xs        = x_q >>> iter_q;
	assign ys        = y_q >>> iter_q;
	assign y_pos     = !y_q[XY_W-1] && (y_q != '0);
	assign y_neg     = y_q[XY_W-1];
	assign atan_v    = wvva_pkg::atan_q16(wvva_pkg::ATAN_IDX_W'(iter_q));
	assign last_step = iter_q == ITER_W'(CORDIC_STEPS - 1);

	// ceiling of the Q.16 angle, folded into 0..359
	assign z_rnd   = z_q + wvva_pkg::ROUND_Q16;
	assign deg_w   = $signed(z_rnd[wvva_pkg::Z_W-1:wvva_pkg::FRAC_W]);
	assign deg_fix = deg_w[DEG_W-1] ? deg_w + DEG_W'(360) : deg_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			iter_q  <= '0;
		end else begin
			case (state_q)
				C_IDLE: begin
					iter_q <= '0;
					if (start) begin
						state_q <= (x_in == '0) ? C_FIN : C_RUN;
					end
				end
				C_RUN: begin
					iter_q <= iter_q + 1'b1;
					if (last_step) begin
						state_q <= C_FIN;
					end
				end
				C_FIN: begin
					state_q <= C_HOLD;
				end
				C_HOLD: begin
					if (take) begin
						state_q <= C_IDLE;
					end
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && start) begin
			if (x_in == '0) begin
				// on the y axis: exact quarter turns, or zero for a null vector
				x_q <= x_ext;
				y_q <= '0;
				if (y_in == '0) begin
					z_q <= '0;
				end else if (y_in[SUM_W-1]) begin
					z_q <= -wvva_pkg::DEG90_Q16;
				end else begin
					z_q <= wvva_pkg::DEG90_Q16;
				end
			end else if (x_in[SUM_W-1]) begin
				// left half plane: rotate by 180 deg first
				x_q <= -x_ext;
				y_q <= -y_ext;
				z_q <= wvva_pkg::DEG180_Q16;
			end else begin
				x_q <= x_ext;
				y_q <= y_ext;
				z_q <= '0;
			end
		end else if (state_q == C_RUN) begin
			if (y_pos) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_v;
			end else if (y_neg) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_v;
			end
		end
		if (state_q == C_FIN) begin
			deg_q <= deg_fix[wvva_pkg::DEG_OUT_W-1:0];
		end
	end

	assign sts.busy      = state_q != C_IDLE;
	assign sts.res_valid = state_q == C_HOLD;
	assign deg           = deg_q;

endmodule

`default_nettype wire

### src/wind_vane_vector_averager_unit.sv
// ----------------------------------------------------------------------------
// wind_vane_vector_averager_unit
// Accumulates vane direction unit vectors; a read returns the average
// direction in degrees and clears the sums.
// ----------------------------------------------------------------------------
//
//   port      dir   kind           payload
//   in_ch     in    valid/ready    op, adc_sample
//   out_ch    out   valid/ready    accepted, open_circuit, direction_deg, has_samples
//
// Sample: accumulated at the transfer edge, result in the output
// register on the next cycle.
// Read with samples: states RUN, FIN and HOLD of the single shift/add CORDIC
// stage, one step per cycle in RUN; in_ch.ready is low until the result moves.
// Read without samples: no CORDIC run; read with a zero cos sum: RUN is skipped (no rotation).
// Reset clears sums, count and all control; out_ch stalls hold the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wind_vane_vector_averager_unit #(
	parameter int COUNT_BITS   = wvva_pkg::COUNT_BITS_DEF,
	parameter int CORDIC_STEPS = wvva_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	wvva_in_if.sink    in_ch,
	wvva_out_if.source out_ch
);

	localparam int SUM_W = COUNT_BITS + wvva_pkg::TRIG_W;

	wvva_pkg::wvva_win_t              win;
	wvva_pkg::wvva_cordic_sts_t       csts;
	logic [wvva_pkg::DEG_OUT_W-1:0]   cordic_deg;

	logic signed [SUM_W-1:0]          cos_sum_q, sin_sum_q;
	logic [COUNT_BITS-1:0]            count_q;

	logic                             out_valid_q;
	logic                             accepted_q, open_circuit_q, has_samples_q;
	logic [wvva_pkg::DEG_OUT_W-1:0]   direction_deg_q;

	logic out_free, in_xfer, cordic_start, res_take, add_sample, have_samples;

	wvva_window u_window (
		.adc_sample (in_ch.adc_sample),
		.win        (win)
	);

	wvva_cordic #(
		.SUM_W        (SUM_W),
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cordic_start),
		.x_in   (cos_sum_q),
		.y_in   (sin_sum_q),
		.take   (res_take),
		.sts    (csts),
		.deg    (cordic_deg)
	);

	assign out_free     = !out_valid_q || out_ch.ready;
	assign in_ch.ready  = !csts.busy && out_free;
	assign in_xfer      = in_ch.valid && in_ch.ready;
	assign have_samples = count_q != '0;
	assign cordic_start = in_xfer && in_ch.op && have_samples;
	assign res_take     = csts.res_valid && out_free;
	// a full count drops the sample
	assign add_sample   = in_xfer && !in_ch.op && win.hit && !(&count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_sum_q   <= '0;
			sin_sum_q   <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (add_sample) begin
				cos_sum_q <= cos_sum_q + SUM_W'(win.cos_v);
				sin_sum_q <= sin_sum_q + SUM_W'(win.sin_v);
				count_q   <= count_q + 1'b1;
			end else if (in_xfer && in_ch.op) begin
				// CORDIC has already latched the sums at this edge
				cos_sum_q <= '0;
				sin_sum_q <= '0;
				count_q   <= '0;
			end
			if ((in_xfer && !cordic_start) || res_take) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			accepted_q      <= 1'b0;
			open_circuit_q  <= 1'b0;
			direction_deg_q <= cordic_deg;
			has_samples_q   <= 1'b1;
		end else if (in_xfer && !cordic_start) begin
			accepted_q      <= add_sample;
			open_circuit_q  <= !in_ch.op && win.open_circuit;
			direction_deg_q <= '0;
			has_samples_q   <= 1'b0;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.accepted      = accepted_q;
	assign out_ch.open_circuit  = open_circuit_q;
	assign out_ch.direction_deg = direction_deg_q;
	assign out_ch.has_samples   = has_samples_q;

endmodule

`default_nettype wire

### src/wvva_checker.sv
// ----------------------------------------------------------------------------
// wvva_checker
// Port-level checks of the averager's results, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wind_vane_vector_averager_unit_macros.svh"

module wvva_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              out_valid,
	input wire logic                              out_ready,
	input wire logic                              accepted,
	input wire logic                              open_circuit,
	input wire logic [wvva_pkg::DEG_OUT_W-1:0]    direction_deg,
	input wire logic                              has_samples
);

	// a stalled result stays offered
	`WVVA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

	// a sample result never carries a direction
	`WVVA_ASSERT_NOW(a_sample_no_dir, out_valid && accepted, !has_samples && direction_deg == '0, "sample result with direction")

	// no window reaches the open-circuit range
	`WVVA_ASSERT_NOW(a_open_not_acc, out_valid && open_circuit, !accepted, "open-circuit sample accumulated")

	// direction stays in 0..359; empty reads report north
	`WVVA_ASSERT_NOW(a_dir_range, out_valid, direction_deg < 9'd360 && (has_samples || direction_deg == '0), "direction out of range")

endmodule

bind wind_vane_vector_averager_unit wvva_checker u_wvva_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_ch.valid),
	.out_ready     (out_ch.ready),
	.accepted      (out_ch.accepted),
	.open_circuit  (out_ch.open_circuit),
	.direction_deg (out_ch.direction_deg),
	.has_samples   (out_ch.has_samples)
);

`default_nettype wire
